>>> rtl/rkc_pkg.sv
package rkc_pkg;

	// defaults for the top level parameters
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_RADIUS_DEF = 2;
	localparam int COEF_BITS_DEF  = 12;

	// kernel geometry: five rows of five 12-bit slots, center at index two
	localparam int KSIDE     = 5;
	localparam int KCENTER   = 2;
	localparam int SLOT_BITS = 12;
	localparam int KROW_BITS = KSIDE * SLOT_BITS;

	// pixel and counter sizes
	localparam int PIX_BITS    = 24;
	localparam int PIX_MAX     = 255;
	localparam int FRAC_BITS   = 8;
	localparam int ROW_BITS    = 18;
	localparam int QUEUE_DEPTH = 4;

	// configuration port
	localparam int CFG_DATA_BITS = 64;
	localparam int CFG_ADDR_BITS = 6;

	typedef enum logic [2:0] {
		REG_RADIUS = 3'd0,
		REG_WIDTH  = 3'd1,
		REG_HEIGHT = 3'd2,
		REG_KROW0  = 3'd3,
		REG_KROW1  = 3'd4,
		REG_KROW2  = 3'd5,
		REG_KROW3  = 3'd6,
		REG_KROW4  = 3'd7
	} rkc_reg_t;

	// per item classification handed from front to back
	typedef struct packed {
		logic carry;
		logic emit;
		logic inrange;
		logic last;
	} rkc_flags_t;

endpackage

>>> rtl/rkc_channels.sv
interface rkc_pix_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;

	modport source (output valid, output op, output red_in, output green_in,
		output blue_in, input ready);
	modport sink (input valid, input op, input red_in, input green_in,
		input blue_in, output ready);
endinterface

interface rkc_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       last_pixel;

	modport source (output valid, output red_out, output green_out, output blue_out,
		output last_pixel, input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		input last_pixel, output ready);
endinterface

>>> rtl/rkc_ram.sv
module rkc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, two registered read ports returning old data on collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end
endmodule

>>> rtl/rkc_queue.sv
module rkc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int PB = $clog2(DEPTH);
	localparam int CB = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PB-1:0]    head_q;
	logic [PB-1:0]    tail_q;
	logic [CB-1:0]    count_q;

	assign full  = (count_q == CB'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = slot_q[head_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[tail_q] <= wdata;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == PB'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= (head_q == PB'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("item pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("item popped from empty queue");
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue level did not follow a push");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(empty || full) |-> (head_q == tail_q))
		else $error("queue pointers disagree with level");
`endif
endmodule

>>> rtl/rkc_front.sv
module rkc_front #(
	parameter int MAX_WIDTH  = rkc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_RADIUS = rkc_pkg::MAX_RADIUS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	rkc_pix_if.sink                          pixels,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]   w_eff,
	input  logic [15:0]                      h_eff,
	input  logic [1:0]                       rad,
	input  logic                             geom_wr,
	input  logic                             q_full,
	output logic                             push,
	output logic [rkc_pkg::PIX_BITS-1:0]     job_pix,
	output logic [$clog2(MAX_WIDTH)-1:0]     job_col,
	output logic [$clog2(2*MAX_RADIUS)-1:0]  job_slot,
	output logic [$clog2(MAX_WIDTH)-1:0]     job_pcol,
	output logic [$clog2(2*MAX_RADIUS)-1:0]  job_pslot,
	output rkc_pkg::rkc_flags_t              job_flags
);
	import rkc_pkg::*;

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int NLINES = 2 * MAX_RADIUS;
	localparam int SB     = $clog2(NLINES);
	localparam int RB     = ROW_BITS;
	localparam int QB     = ROW_BITS + WW;

	logic [CW-1:0] in_col_q, out_col_q;
	logic [RB-1:0] in_row_q, out_row_q;
	logic [SB-1:0] in_slot_q, out_slot_q;
	logic [QB-1:0] q_q, p_q, lag_q;
	logic          recalc_q;

	logic          take, in_live, ignore, adv, emit, in_wrap, out_wrap, last, inrange;
	logic [RB-1:0] out_row_nx;

	// classify the offered item against the position counters
	always_comb begin
		pixels.ready = !q_full && !recalc_q && !geom_wr;
		take         = pixels.valid && pixels.ready;
		in_live      = in_row_q < RB'(h_eff);
		ignore       = pixels.op && in_live;
		adv          = take && !ignore;
		emit         = {1'b0, q_q} >= ({1'b0, p_q} + {1'b0, lag_q});
		in_wrap      = (WW'(in_col_q) + WW'(1)) >= w_eff;
		out_wrap     = (WW'(out_col_q) + WW'(1)) >= w_eff;
		out_row_nx   = out_wrap ? out_row_q + 1'b1 : out_row_q;
		last         = emit && (out_row_nx >= RB'(h_eff));
		inrange      = (out_row_q >= RB'(rad)) && (out_col_q >= CW'(rad))
			&& ((out_row_q + RB'(rad)) < RB'(h_eff))
			&& (((WW+1)'(out_col_q) + (WW+1)'(rad)) < (WW+1)'(w_eff));
	end

	assign push              = adv;
	assign job_pix           = {pixels.red_in, pixels.green_in, pixels.blue_in};
	assign job_col           = in_col_q;
	assign job_slot          = in_slot_q;
	assign job_pcol          = out_col_q;
	assign job_pslot         = out_slot_q;
	assign job_flags.carry   = !pixels.op && in_live;
	assign job_flags.emit    = emit;
	assign job_flags.inrange = inrange;
	assign job_flags.last    = last;

	// input and output raster positions, linear indexes and result lag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			q_q        <= '0;
			p_q        <= '0;
			lag_q      <= QB'(MAX_WIDTH_DEF + 1);
			recalc_q   <= 1'b1;
		end else begin
			recalc_q <= geom_wr;
			if (recalc_q) begin
				// rebuild linear indexes after a geometry change
				q_q   <= QB'(QB'(in_row_q) * QB'(w_eff)) + QB'(in_col_q);
				p_q   <= QB'(QB'(out_row_q) * QB'(w_eff)) + QB'(out_col_q);
				lag_q <= QB'(QB'(rad) * QB'(w_eff)) + QB'(rad);
			end else if (adv) begin
				if (last) begin
					in_col_q   <= '0;
					in_row_q   <= '0;
					in_slot_q  <= '0;
					out_col_q  <= '0;
					out_row_q  <= '0;
					out_slot_q <= '0;
					q_q        <= '0;
					p_q        <= '0;
				end else begin
					if (in_wrap) begin
						in_col_q  <= '0;
						in_row_q  <= in_row_q + 1'b1;
						in_slot_q <= (in_slot_q == SB'(NLINES - 1)) ? '0 : in_slot_q + 1'b1;
						q_q       <= q_q - QB'(in_col_q) + QB'(w_eff);
					end else begin
						in_col_q <= in_col_q + 1'b1;
						q_q      <= q_q + 1'b1;
					end
					if (emit) begin
						out_row_q <= out_row_nx;
						if (out_wrap) begin
							out_col_q  <= '0;
							out_slot_q <= (out_slot_q == SB'(NLINES - 1)) ? '0
								: out_slot_q + 1'b1;
							p_q        <= p_q - QB'(out_col_q) + QB'(w_eff);
						end else begin
							out_col_q <= out_col_q + 1'b1;
							p_q       <= p_q + 1'b1;
						end
					end
				end
			end
		end
	end
endmodule

>>> rtl/rkc_back.sv
module rkc_back #(
	parameter int MAX_WIDTH  = rkc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_RADIUS = rkc_pkg::MAX_RADIUS_DEF,
	parameter int COEF_BITS  = rkc_pkg::COEF_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [rkc_pkg::KROW_BITS-1:0]    krow [rkc_pkg::KSIDE],
	input  logic [1:0]                       rad,
	input  logic                             head_valid,
	input  logic [rkc_pkg::PIX_BITS-1:0]     head_pix,
	input  logic [$clog2(MAX_WIDTH)-1:0]     head_col,
	input  logic [$clog2(2*MAX_RADIUS)-1:0]  head_slot,
	input  logic [$clog2(MAX_WIDTH)-1:0]     head_pcol,
	input  logic [$clog2(2*MAX_RADIUS)-1:0]  head_pslot,
	input  rkc_pkg::rkc_flags_t              head_flags,
	output logic                             pop,
	rkc_res_if.source                        results
);
	import rkc_pkg::*;

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int NLINES = 2 * MAX_RADIUS;
	localparam int SB     = $clog2(NLINES);
	localparam int WSIDE  = 2 * MAX_RADIUS + 1;
	localparam int KW     = (WSIDE < KSIDE) ? WSIDE : KSIDE;
	localparam int PB     = COEF_BITS + 9;
	localparam int SW     = PB + 5;

	logic                en;
	logic [PIX_BITS-1:0] rd_a [NLINES];
	logic [PIX_BITS-1:0] rd_b [NLINES];

	// stage registers
	logic                v_s1, v_s2, v_s3, v_s4;
	rkc_flags_t          flags_s1, flags_s2, flags_s3, flags_s4;
	logic [PIX_BITS-1:0] pix_s1, pass_s2, pass_s3, pass_s4;
	logic [SB-1:0]       slot_s1, pslot_s1;
	logic                fwd_s1;
	logic [PIX_BITS-1:0] win_q [WSIDE][WSIDE];
	logic signed [PB-1:0] prod_s3 [3][KW][KW];
	logic signed [SW-1:0] rsum_s4 [3][KW];
	logic [7:0]           red_q, green_q, blue_q;
	logic                 last_q, out_v_q;

	logic signed [COEF_BITS-1:0] cf [KW][KW];
	logic signed [SW-1:0]        rsum [3][KW];
	logic signed [SW-1:0]        total [3];
	logic [7:0]                  chan [3];
	logic [PIX_BITS-1:0]         pass_s1;
	logic [PIX_BITS-1:0]         fill [NLINES];

	assign en  = !out_v_q || results.ready;
	assign pop = en && head_valid;

	// line buffers, one memory per buffered row
	for (genvar l = 0; l < NLINES; l++) begin : g_line
		rkc_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_line (
			.clk     (clk),
			.we      (pop && head_flags.carry && (head_slot == SB'(l))),
			.waddr   (head_col),
			.wdata   (head_pix),
			.re      (en),
			.raddr_a (head_col),
			.rdata_a (rd_a[l]),
			.raddr_b (head_pcol),
			.rdata_b (rd_b[l])
		);
	end

	// rows older by k lines come from the buffer k slots behind the write slot
	always_comb begin
		for (int k = 1; k <= NLINES; k++) begin
			if (int'(slot_s1) >= k) begin
				fill[k-1] = rd_a[int'(slot_s1) - k];
			end else begin
				fill[k-1] = rd_a[int'(slot_s1) + NLINES - k];
			end
		end
		pass_s1 = fwd_s1 ? pix_s1 : rd_b[pslot_s1];
	end

	// coefficient for each tap, aligned to the bottom right of the window
	always_comb begin
		logic [2:0] ki, kj;
		for (int da = 0; da < KW; da++) begin
			for (int db = 0; db < KW; db++) begin
				ki = 3'(KCENTER + int'(rad) - da);
				kj = 3'(KCENTER + int'(rad) - db);
				cf[da][db] = '0;
				if ((da <= 2 * int'(rad)) && (db <= 2 * int'(rad))) begin
					cf[da][db] = krow[ki][SLOT_BITS * kj +: COEF_BITS];
				end
			end
		end
	end

	// row sums of the tap products
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int da = 0; da < KW; da++) begin
				rsum[ch][da] = '0;
				for (int db = 0; db < KW; db++) begin
					rsum[ch][da] = rsum[ch][da] + SW'(prod_s3[ch][da][db]);
				end
			end
		end
	end

	// final adds and clamp to the pixel range
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			total[ch] = '0;
			for (int da = 0; da < KW; da++) begin
				total[ch] = total[ch] + rsum_s4[ch][da];
			end
			if (total[ch] < 0) begin
				chan[ch] = '0;
			end else if (total[ch] >= SW'(PIX_MAX * (1 << FRAC_BITS))) begin
				chan[ch] = 8'(PIX_MAX);
			end else begin
				chan[ch] = total[ch][FRAC_BITS +: 8];
			end
		end
	end

	// stage valids and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1    <= pop;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			out_v_q <= v_s4 && flags_s4.emit;
		end
	end

	// neighborhood window, shifted one column per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < WSIDE; a++) begin
				for (int b = 0; b < WSIDE; b++) begin
					win_q[a][b] <= '0;
				end
			end
		end else if (en && v_s1) begin
			for (int a = 0; a < WSIDE; a++) begin
				for (int b = 0; b < WSIDE - 1; b++) begin
					win_q[a][b] <= win_q[a][b+1];
				end
			end
			for (int k = 1; k <= NLINES; k++) begin
				win_q[WSIDE-1-k][WSIDE-1] <= fill[k-1];
			end
			win_q[WSIDE-1][WSIDE-1] <= flags_s1.carry ? pix_s1 : '0;
		end
	end

	// payload pipeline: products, row sums, output register
	always_ff @(posedge clk) begin
		if (en) begin
			flags_s1 <= head_flags;
			pix_s1   <= head_pix;
			slot_s1  <= head_slot;
			pslot_s1 <= head_pslot;
			fwd_s1   <= head_flags.carry && (head_slot == head_pslot)
				&& (head_col == head_pcol);

			flags_s2 <= flags_s1;
			pass_s2  <= pass_s1;

			flags_s3 <= flags_s2;
			pass_s3  <= pass_s2;
			// taps outside the active kernel contribute nothing
			for (int ch = 0; ch < 3; ch++) begin
				for (int da = 0; da < KW; da++) begin
					for (int db = 0; db < KW; db++) begin
						if ((da <= 2 * int'(rad)) && (db <= 2 * int'(rad))) begin
							prod_s3[ch][da][db] <= PB'($signed({1'b0,
								win_q[WSIDE-1-da][WSIDE-1-db][16 - 8 * ch +: 8]})
								* cf[da][db]);
						end else begin
							prod_s3[ch][da][db] <= '0;
						end
					end
				end
			end

			flags_s4 <= flags_s3;
			pass_s4  <= pass_s3;
			for (int ch = 0; ch < 3; ch++) begin
				for (int da = 0; da < KW; da++) begin
					rsum_s4[ch][da] <= rsum[ch][da];
				end
			end

			red_q   <= flags_s4.inrange ? chan[0] : pass_s4[23:16];
			green_q <= flags_s4.inrange ? chan[1] : pass_s4[15:8];
			blue_q  <= flags_s4.inrange ? chan[2] : pass_s4[7:0];
			last_q  <= flags_s4.last;
		end
	end

	assign results.valid      = out_v_q;
	assign results.red_out    = red_q;
	assign results.green_out  = green_q;
	assign results.blue_out   = blue_q;
	assign results.last_pixel = last_q;
endmodule

>>> rtl/rgb_kernel_convolution.sv
// channel   dir  handshake        payload
// pixels    in   valid / ready    op, red_in, green_in, blue_in
// results   out  valid / ready    red_out, green_out, blue_out, last_pixel
// apb       in   psel / penable   paddr, pwdata, prdata (8-byte registers)
//
// one item per clock while the queue has room and no geometry update holds
// ready low; the item that causes a result passes the queue, stage registers
// and output register, and trails its pixel by radius rows plus radius pixels
// the front holds ready low during a width or radius write and the cycle after,
// while it rebuilds its position indexes with three parallel multiplies
// the line buffers need no clearing pass after reset
// a stalled result port fills the four-entry queue before input ready drops
module rgb_kernel_convolution #(
	parameter int MAX_WIDTH  = rkc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_RADIUS = rkc_pkg::MAX_RADIUS_DEF,
	parameter int COEF_BITS  = rkc_pkg::COEF_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	rkc_pix_if.sink                           pixels,
	rkc_res_if.source                         results,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rkc_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [rkc_pkg::CFG_DATA_BITS-1:0] pwdata,
	output logic [rkc_pkg::CFG_DATA_BITS-1:0] prdata,
	output logic                              pready
);
	import rkc_pkg::*;

	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int SB     = $clog2(2 * MAX_RADIUS);
	localparam int JOB_W  = PIX_BITS + 2 * CW + 2 * SB + $bits(rkc_flags_t);

	logic [1:0]           radius_q;
	logic [10:0]          width_q;
	logic [15:0]          height_q;
	logic [KROW_BITS-1:0] krow_q [KSIDE];

	rkc_reg_t             idx;
	logic                 wr, geom_wr;
	logic [WW-1:0]        w_eff;
	logic [15:0]          h_eff;
	logic [1:0]           rad;
	logic [31:0]          w_wide;

	logic                 push, pop, q_full, q_empty;
	logic [PIX_BITS-1:0]  job_pix, head_pix;
	logic [CW-1:0]        job_col, job_pcol, head_col, head_pcol;
	logic [SB-1:0]        job_slot, job_pslot, head_slot, head_pslot;
	rkc_flags_t           job_flags, head_flags;
	logic [JOB_W-1:0]     head_job;

	assign pready  = 1'b1;
	assign idx     = rkc_reg_t'(paddr[5:3]);
	assign wr      = psel && penable && pwrite;
	assign geom_wr = wr && ((idx == REG_RADIUS) || (idx == REG_WIDTH));

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= 2'd1;
			width_q   <= 11'd1024;
			height_q  <= 16'd1024;
			krow_q[0] <= '0;
			krow_q[1] <= '0;
			krow_q[2] <= KROW_BITS'(64'h1_0000_0000);
			krow_q[3] <= '0;
			krow_q[4] <= '0;
		end else if (wr) begin
			case (idx)
				REG_RADIUS: radius_q  <= pwdata[1:0];
				REG_WIDTH:  width_q   <= pwdata[10:0];
				REG_HEIGHT: height_q  <= pwdata[15:0];
				REG_KROW0:  krow_q[0] <= pwdata[KROW_BITS-1:0];
				REG_KROW1:  krow_q[1] <= pwdata[KROW_BITS-1:0];
				REG_KROW2:  krow_q[2] <= pwdata[KROW_BITS-1:0];
				REG_KROW3:  krow_q[3] <= pwdata[KROW_BITS-1:0];
				REG_KROW4:  krow_q[4] <= pwdata[KROW_BITS-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (idx)
			REG_RADIUS: prdata = CFG_DATA_BITS'(radius_q);
			REG_WIDTH:  prdata = CFG_DATA_BITS'(width_q);
			REG_HEIGHT: prdata = CFG_DATA_BITS'(height_q);
			REG_KROW0:  prdata = CFG_DATA_BITS'(krow_q[0]);
			REG_KROW1:  prdata = CFG_DATA_BITS'(krow_q[1]);
			REG_KROW2:  prdata = CFG_DATA_BITS'(krow_q[2]);
			REG_KROW3:  prdata = CFG_DATA_BITS'(krow_q[3]);
			REG_KROW4:  prdata = CFG_DATA_BITS'(krow_q[4]);
			default:    prdata = '0;
		endcase
	end

	// effective geometry: zero sizes act as one, radius limited to the window
	always_comb begin
		w_wide = 32'(width_q);
		if (w_wide == 32'd0) begin
			w_eff = WW'(1);
		end else if (w_wide > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(w_wide);
		end
		h_eff = (height_q == 16'd0) ? 16'd1 : height_q;
		rad   = radius_q;
		if (32'(rad) > 32'(MAX_RADIUS)) begin
			rad = 2'(MAX_RADIUS);
		end
		if (32'(rad) > 32'(KCENTER)) begin
			rad = 2'(KCENTER);
		end
	end

	rkc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pixels),
		.w_eff     (w_eff),
		.h_eff     (h_eff),
		.rad       (rad),
		.geom_wr   (geom_wr),
		.q_full    (q_full),
		.push      (push),
		.job_pix   (job_pix),
		.job_col   (job_col),
		.job_slot  (job_slot),
		.job_pcol  (job_pcol),
		.job_pslot (job_pslot),
		.job_flags (job_flags)
	);

	rkc_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({job_pix, job_col, job_slot, job_pcol, job_pslot, job_flags}),
		.pop    (pop),
		.rdata  (head_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign {head_pix, head_col, head_slot, head_pcol, head_pslot, head_flags} = head_job;

	rkc_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS), .COEF_BITS(COEF_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.krow       (krow_q),
		.rad        (rad),
		.head_valid (!q_empty),
		.head_pix   (head_pix),
		.head_col   (head_col),
		.head_slot  (head_slot),
		.head_pcol  (head_pcol),
		.head_pslot (head_pslot),
		.head_flags (head_flags),
		.pop        (pop),
		.results    (results)
	);
endmodule

>>> test/rgb_kernel_convolution_tb.sv
`timescale 1ns / 1ps

module rgb_kernel_convolution_tb;
	import rkc_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE_CYCLES = 16;
	localparam int LINE_COUNT = 4;
	localparam int LINE_LEN = 1024;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} conv_result_t;

	// predicts the filtered pixel stream and checks the block's output against it
	class conv_scoreboard;
		bit [1:0]  radius;
		bit [10:0] width;
		bit [15:0] height;
		bit [59:0] krow [KSIDE];
		bit [23:0] lines [LINE_COUNT][LINE_LEN];
		bit [23:0] win [KSIDE][KSIDE];
		int unsigned in_col, in_row, out_col, out_row;
		conv_result_t expected_q [$];
		int fails;
		bit frame_closed;

		function new();
			radius = 1;
			width = 1024;
			height = 1024;
			foreach (krow[i]) krow[i] = '0;
			krow[KCENTER] = 60'h0_0001_0000_0000;
			foreach (win[a, b]) win[a][b] = '0;
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
			fails = 0;
			frame_closed = 0;
		endfunction

		function void set_reg(rkc_reg_t idx, logic [63:0] v);
			case (idx)
				REG_RADIUS: radius = v[1:0];
				REG_WIDTH:  width = v[10:0];
				REG_HEIGHT: height = v[15:0];
				REG_KROW0:  krow[0] = v[59:0];
				REG_KROW1:  krow[1] = v[59:0];
				REG_KROW2:  krow[2] = v[59:0];
				REG_KROW3:  krow[3] = v[59:0];
				REG_KROW4:  krow[4] = v[59:0];
				default: ;
			endcase
		endfunction

		function int eff_w();
			return width == 0 ? 1 : (width > LINE_LEN ? LINE_LEN : int'(width));
		endfunction

		function int eff_h();
			return height == 0 ? 1 : int'(height);
		endfunction

		function int coef(int i, int j);
			logic [11:0] s;
			s = krow[i][SLOT_BITS*j +: SLOT_BITS];
			return $signed(s);
		endfunction

		function logic [7:0] clamp_sum(longint s);
			if (s < 0) return 8'd0;
			if ((s >>> FRAC_BITS) > PIX_MAX) return 8'd255;
			return s[15:8];
		endfunction

		// one accepted input item
		function void note_item(bit op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
			int w, h, rad, slot;
			bit carry, inrange;
			bit [23:0] pix, p;
			longint q, pidx, sr, sg, sb;
			conv_result_t e;
			w = eff_w();
			h = eff_h();
			rad = radius > 2 ? 2 : radius;
			// drains are dropped while the frame is still coming in
			if (op && in_row < h) return;
			carry = !op && in_row < h;
			pix = {r, g, b};
			q = longint'(in_row) * w + in_col;
			// shift the window and load the new column from the line store
			for (int a = 0; a < KSIDE; a++)
				for (int c = 0; c < KSIDE - 1; c++)
					win[a][c] = win[a][c + 1];
			for (int k = 1; k <= LINE_COUNT; k++) begin
				slot = (in_row % LINE_COUNT + LINE_COUNT - k) % LINE_COUNT;
				win[KSIDE - 1 - k][KSIDE - 1] = lines[slot][in_col % LINE_LEN];
			end
			win[KSIDE - 1][KSIDE - 1] = carry ? pix : 24'd0;
			if (carry) lines[in_row % LINE_COUNT][in_col % LINE_LEN] = pix;
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
			pidx = longint'(out_row) * w + out_col;
			if (q < pidx + rad * w + rad) return;
			inrange = out_row >= rad && out_col >= rad && out_row + rad < h && out_col + rad < w;
			if (inrange) begin
				sr = 0;
				sg = 0;
				sb = 0;
				for (int i = 0; i <= 2 * rad; i++)
					for (int j = 0; j <= 2 * rad; j++) begin
						p = win[KSIDE - 1 - 2 * rad + i][KSIDE - 1 - 2 * rad + j];
						sr += longint'(p[23:16]) * coef(KCENTER - rad + i, KCENTER - rad + j);
						sg += longint'(p[15:8]) * coef(KCENTER - rad + i, KCENTER - rad + j);
						sb += longint'(p[7:0]) * coef(KCENTER - rad + i, KCENTER - rad + j);
					end
				e.red = clamp_sum(sr);
				e.green = clamp_sum(sg);
				e.blue = clamp_sum(sb);
			end else begin
				// near an edge the pixel passes through
				p = lines[out_row % LINE_COUNT][out_col % LINE_LEN];
				e.red = p[23:16];
				e.green = p[15:8];
				e.blue = p[7:0];
			end
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
			e.last = out_row >= h;
			if (e.last) begin
				in_col = 0;
				in_row = 0;
				out_col = 0;
				out_row = 0;
				frame_closed = 1;
			end
			expected_q = {expected_q, e};
		endfunction

		function void check_result(conv_result_t got);
			conv_result_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result rgb %0d %0d %0d last %0b", $time,
					got.red, got.green, got.blue, got.last);
				fails++;
				return;
			end
			e = expected_q.pop_front();
			if (got.red !== e.red || got.green !== e.green || got.blue !== e.blue ||
					got.last !== e.last) begin
				$display("%0t: mismatch expected rgb %0d %0d %0d last %0b, actual rgb %0d %0d %0d last %0b",
					$time, e.red, e.green, e.blue, e.last, got.red, got.green, got.blue, got.last);
				fails++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	int unsigned cycles = 0;
	int          burst_left;
	int          ready_mode = 0;
	int          mode_left = 0;
	int          random_items;
	conv_scoreboard sb = new();

	rkc_pix_if pix ();
	rkc_res_if res ();

	rgb_kernel_convolution uut (
		.clk(clk),
		.arst_n(arst_n),
		.pixels(pix),
		.results(res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver stalls in randomly chosen modes: always, mostly or seldom ready
	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode <= $urandom_range(0, 2);
			mode_left <= $urandom_range(16, 64);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (ready_mode)
			0: res.ready <= 1'b1;
			1: res.ready <= $urandom_range(0, 3) != 0;
			default: res.ready <= $urandom_range(0, 4) == 0;
		endcase
	end

	// result monitor
	always @(posedge clk) begin
		conv_result_t got;
		if (res.valid && res.ready) begin
			got.red = res.red_out;
			got.green = res.green_out;
			got.blue = res.blue_out;
			got.last = res.last_pixel;
			sb.check_result(got);
		end
	end

	task automatic write_reg(rkc_reg_t idx, logic [63:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	// sends one item, with bursts and gaps on the sender side
	task automatic send_item(bit op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				pix.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(40, 80) : $urandom_range(1, 12);
		end
		burst_left--;
		pix.valid <= 1'b1;
		pix.op <= op;
		pix.red_in <= r;
		pix.green_in <= g;
		pix.blue_in <= b;
		do @(posedge clk); while (!pix.ready);
		sb.note_item(op, r, g, b);
	endtask

	// stop sending and let every expected result come back
	task automatic drain_wait();
		pix.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [59:0] rand_krow();
		logic [59:0] v;
		for (int j = 0; j < KSIDE; j++)
			v[SLOT_BITS*j +: SLOT_BITS] = $urandom_range(0, 3) == 0 ? 12'($urandom) :
				12'($urandom_range(0, 120) - 40);
		return v;
	endfunction

	// one whole frame: pixels with stray drains, then tail items until the last result
	task automatic run_frame(int drain_pct);
		int n;
		n = 0;
		sb.frame_closed = 0;
		for (int i = 0; i < sb.eff_w() * sb.eff_h(); i++) begin
			if ($urandom_range(0, 99) < drain_pct) send_item(1'b1, rand_chan(), rand_chan(), rand_chan());
			send_item(1'b0, rand_chan(), rand_chan(), rand_chan());
			n++;
		end
		while (!sb.frame_closed) begin
			send_item(1'($urandom_range(0, 1)), rand_chan(), rand_chan(), rand_chan());
			n++;
		end
		random_items += n;
		drain_wait();
	endtask

	task automatic set_geometry(int rad, int w, int h);
		write_reg(REG_RADIUS, 64'(rad));
		write_reg(REG_WIDTH, 64'(w));
		write_reg(REG_HEIGHT, 64'(h));
	endtask

	initial begin
		arst_n = 1'b0;
		burst_left = 0;
		random_items = 0;
		pix.valid = 1'b0;
		pix.op = 1'b0;
		pix.red_in = '0;
		pix.green_in = '0;
		pix.blue_in = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed frame: 4x3, radius one, extreme coefficients and pixel values
		set_geometry(1, 4, 3);
		write_reg(REG_KROW0, 60'h7FF_800_7FF_800_7FF);
		write_reg(REG_KROW1, 60'h000_800_100_7FF_000);
		write_reg(REG_KROW2, 60'h000_020_100_040_000);
		write_reg(REG_KROW3, 60'h000_FC0_080_FFF_000);
		write_reg(REG_KROW4, 60'h800_7FF_800_7FF_800);
		sb.frame_closed = 0;
		for (int i = 0; i < 12; i++) begin
			// a drain during input is ignored
			if (i == 3 || i == 8) send_item(1'b1, 8'd255, 8'd255, 8'd255);
			send_item(1'b0, (i % 2) ? 8'd255 : 8'd0, (i % 3) ? 8'd0 : 8'd255, 8'(i * 21));
		end
		// tail: a pixel here behaves as a drain
		for (int i = 0; !sb.frame_closed; i++)
			send_item(1'(i % 2), 8'd200, 8'd17, 8'd99);
		drain_wait();

		// register extremes and values that fold to the limits
		set_geometry(0, 1, 1);
		run_frame(0);
		set_geometry(3, 0, 0);
		run_frame(20);
		set_geometry(2, 5, 5);
		write_reg(REG_KROW2, rand_krow());
		run_frame(10);

		// random frames of small size
		while (random_items < 500) begin
			set_geometry($urandom_range(0, 3), $urandom_range(0, 12), $urandom_range(0, 8));
			for (int k = 0; k < KSIDE; k++)
				if ($urandom_range(0, 1)) write_reg(rkc_reg_t'(REG_KROW0 + k), rand_krow());
			run_frame($urandom_range(0, 15));
		end

		drain_wait();
		if (sb.fails == 0 && sb.expected_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
